[hw/rtl/datediff_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// datediff_pkg
// Types, widths and month-length table shared by the day-count block.
// ----------------------------------------------------------------------------
package datediff_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OUT_W   = 23;
    localparam int ACC_W   = 24;
    localparam int C100_W  = 7;
    localparam int C400_W  = 9;

    localparam int unsigned YEAR_FIELD_MAX = (1 << YEAR_W) - 1;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    localparam logic [C100_W-1:0] C100_LAST = C100_W'(99);
    localparam logic [C400_W-1:0] C400_LAST = C400_W'(399);

    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP   = 9'd366;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YEARS,
        ST_MONTHS,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic year_step;
        logic month_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic year_last;
        logic month_done;
    } t_status;

    // Length of a month; any code outside 1..12 counts as February.
    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            default:                                    len = leap ? 5'd29 : 5'd28;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/datediff_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// datediff_ctrl
// Sequencer: load, walk the years, walk the months, finish.
// ----------------------------------------------------------------------------
module datediff_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    input  datediff_pkg::t_status i_status,
    output datediff_pkg::t_cmd    o_cmd,
    output logic                  busy
);
    import datediff_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_YEARS;
                end
            end
            ST_YEARS: begin
                o_cmd.year_step = 1'b1;
                if (i_status.year_last) begin
                    n_state = ST_MONTHS;
                end
            end
            ST_MONTHS: begin
                if (i_status.month_done) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/datediff_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// datediff_dp
// Operand registers, year walker with leap counters, month walker,
// accumulator and saturating result register.
// ----------------------------------------------------------------------------
module datediff_dp #(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  datediff_pkg::t_cmd                    i_cmd,
    input  wire  [datediff_pkg::YEAR_W-1:0]       i_start_year,
    input  wire  [datediff_pkg::MONTH_W-1:0]      i_start_month,
    input  wire  [datediff_pkg::DAY_W-1:0]        i_start_day,
    input  wire  [datediff_pkg::YEAR_W-1:0]       i_end_year,
    input  wire  [datediff_pkg::MONTH_W-1:0]      i_end_month,
    input  wire  [datediff_pkg::DAY_W-1:0]        i_end_day,
    output datediff_pkg::t_status                 o_status,
    output logic                                  o_valid,
    output logic signed [datediff_pkg::OUT_W-1:0] o_day_count
);
    import datediff_pkg::*;

    localparam int unsigned YMAX_C = (YEAR_MAX > YEAR_FIELD_MAX) ? YEAR_FIELD_MAX : YEAR_MAX;
    localparam logic [YEAR_W-1:0] YMAX_W = YEAR_W'(YMAX_C);

    logic [YEAR_W-1:0]        r_sy, r_ey, r_year;
    logic [C100_W-1:0]        r_c100;
    logic [C400_W-1:0]        r_c400;
    logic [MONTH_W-1:0]       r_mon, r_mon_hi;
    logic                     r_neg, r_leap;
    logic [DAY_W-1:0]         r_sd, r_ed;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_valid;
    logic signed [OUT_W-1:0]  r_out;

    logic [YEAR_W-1:0]        sy_clamp, ey_clamp;
    logic                     leap_now;
    logic [8:0]               year_len;
    logic [4:0]               mlen;
    logic signed [ACC_W-1:0]  total;

    assign sy_clamp = (i_start_year > YMAX_W) ? YMAX_W : i_start_year;
    assign ey_clamp = (i_end_year   > YMAX_W) ? YMAX_W : i_end_year;

    // Leap under the 4/100/400 rule, tracked by counters that follow the year.
    assign leap_now = ((r_year[1:0] == 2'b00) && (r_c100 != '0)) || (r_c400 == '0);
    assign year_len = leap_now ? DAYS_LEAP : DAYS_COMMON;
    assign mlen     = month_len(r_mon, r_leap);

    assign total = r_acc + ACC_W'(signed'({1'b0, r_ed})) - ACC_W'(signed'({1'b0, r_sd}));

    assign o_status.year_last  = (r_year == r_ey);
    assign o_status.month_done = (r_mon == r_mon_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sy   <= sy_clamp;
            r_ey   <= ey_clamp;
            r_sd   <= i_start_day;
            r_ed   <= i_end_day;
            r_year <= '0;
            r_c100 <= '0;
            r_c400 <= '0;
            r_acc  <= '0;
            if (i_start_month <= i_end_month) begin
                r_mon    <= i_start_month;
                r_mon_hi <= i_end_month;
                r_neg    <= 1'b0;
            end else begin
                r_mon    <= i_end_month;
                r_mon_hi <= i_start_month;
                r_neg    <= 1'b1;
            end
        end
        if (i_cmd.year_step) begin
            if (r_year == r_ey) begin
                // February length follows the end year.
                r_leap <= leap_now;
            end else begin
                if (r_year >= r_sy) begin
                    r_acc <= r_acc + ACC_W'(year_len);
                end
                r_year <= r_year + YEAR_W'(1);
                r_c100 <= (r_c100 == C100_LAST) ? '0 : r_c100 + C100_W'(1);
                r_c400 <= (r_c400 == C400_LAST) ? '0 : r_c400 + C400_W'(1);
            end
        end
        if (i_cmd.month_step) begin
            if (r_neg) begin
                r_acc <= r_acc - ACC_W'(mlen);
            end else begin
                r_acc <= r_acc + ACC_W'(mlen);
            end
            r_mon <= r_mon + MONTH_W'(1);
        end
        if (i_cmd.finish) begin
            if (total > SAT_HI) begin
                r_out <= SAT_HI[OUT_W-1:0];
            end else if (total < SAT_LO) begin
                r_out <= SAT_LO[OUT_W-1:0];
            end else begin
                r_out <= total[OUT_W-1:0];
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_day_count = r_out;

endmodule
`default_nettype wire

[hw/rtl/date_difference_in_days_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// date_difference_in_days_top
// Signed day count between two Gregorian dates.
//
//   channel   handshake          payload
//   input     start / busy       i_start_year .. i_end_day
//   result    o_valid (strobe)   o_day_count
//
// The year walker takes one cycle per year from 0 through the clamped end
// year; the month walker takes one month a cycle, over 0..15 months.
// busy is high from the cycle after start until the result strobe.
// Reset is synchronous, active low, and returns the sequencer to idle.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module date_difference_in_days_top #(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire  [datediff_pkg::YEAR_W-1:0]       i_start_year,
    input  wire  [datediff_pkg::MONTH_W-1:0]      i_start_month,
    input  wire  [datediff_pkg::DAY_W-1:0]        i_start_day,
    input  wire  [datediff_pkg::YEAR_W-1:0]       i_end_year,
    input  wire  [datediff_pkg::MONTH_W-1:0]      i_end_month,
    input  wire  [datediff_pkg::DAY_W-1:0]        i_end_day,
    output logic                                  o_valid,
    output logic signed [datediff_pkg::OUT_W-1:0] o_day_count
);
    import datediff_pkg::*;

    t_cmd    cmd;
    t_status status;

    datediff_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    datediff_dp #(
        .YEAR_MAX (YEAR_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_start_year  (i_start_year),
        .i_start_month (i_start_month),
        .i_start_day   (i_start_day),
        .i_end_year    (i_end_year),
        .i_end_month   (i_end_month),
        .i_end_day     (i_end_day),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_day_count   (o_day_count)
    );

`ifndef ASSERT_OFF
    // An accepted transaction makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // A result strobe only follows a busy cycle.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    // The block is idle while the result is shown.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy during result strobe");

    // The month walker never overruns its end.
    a_month_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.month_step |-> !status.month_done)
        else $error("month step past the end month");
`endif

endmodule
`default_nettype wire
